// ----- design/ppws_pkg.sv -----
`default_nettype none
package ppws_pkg;

    // sizing
    localparam int MAX_TARGETS = 64;
    localparam int WINDOW_LEN  = 10;

    // fixed field widths
    localparam int TID_W     = 6;
    localparam int STAT_W    = 3;
    localparam int RTT_W     = 16;
    localparam int CNT_W     = 4;
    localparam int SUM_OUT_W = 20;
    localparam int TOT_W     = 32;

    // derived widths
    localparam int TADDR_W = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
    localparam int WADDR_W = (MAX_TARGETS * WINDOW_LEN > 1) ?
                             $clog2(MAX_TARGETS * WINDOW_LEN) : 1;
    localparam int HEAD_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int FILL_W  = $clog2(WINDOW_LEN + 1);
    localparam int SUM_W   = RTT_W + FILL_W;
    localparam int META_W  = 2 * TOT_W + FILL_W + HEAD_W;

    // front-to-back queue
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // status codes
    localparam logic [STAT_W-1:0] STATUS_OK  = 3'd0;
    localparam logic [STAT_W-1:0] STATUS_GAP = 3'd6;

    localparam logic [RTT_W-1:0] MISSING_RESET = 16'hFFFF;

    typedef struct packed {
        logic [TID_W-1:0]  tid;
        logic [STAT_W-1:0] status;
        logic [RTT_W-1:0]  rtt;
    } t_job;

    typedef struct packed {
        logic [TOT_W-1:0]  sent;
        logic [TOT_W-1:0]  lost;
        logic [FILL_W-1:0] fill;
        logic [HEAD_W-1:0] head;
    } t_meta;

    typedef struct packed {
        logic [TID_W-1:0]     target_id_res;
        logic [CNT_W-1:0]     window_count;
        logic [CNT_W-1:0]     window_lost;
        logic [CNT_W-1:0]     rtt_valid_count;
        logic [RTT_W-1:0]     rtt_min;
        logic [RTT_W-1:0]     rtt_max;
        logic [SUM_OUT_W-1:0] rtt_sum;
        logic [TOT_W-1:0]     total_sent;
        logic [TOT_W-1:0]     total_lost;
        logic [STAT_W-1:0]    last_status;
        logic [RTT_W-1:0]     last_rtt;
    } t_res;

    // saturate a window count into the result width
    function automatic logic [CNT_W-1:0] sat_cnt(input logic [FILL_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (int'(v) > (2 ** CNT_W - 1)) r = '1;
        else r = CNT_W'(v);
        return r;
    endfunction

    // saturate the window sum into the result width
    function automatic logic [SUM_OUT_W-1:0] sat_sum(input logic [SUM_W-1:0] v);
        logic [SUM_OUT_W-1:0] r;
        if (longint'(v) > (longint'(1) << SUM_OUT_W) - 1) r = '1;
        else r = SUM_OUT_W'(v);
        return r;
    endfunction

    function automatic logic [TOT_W-1:0] sat_inc(input logic [TOT_W-1:0] v);
        logic [TOT_W-1:0] r;
        if (&v) r = v;
        else r = v + 1'b1;
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- design/ppws_ram.sv -----
`default_nettype none
module ppws_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ----- design/ppws_front.sv -----
`default_nettype none
module ppws_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_push,
    output logic                             o_full,
    input  wire logic [ppws_pkg::TID_W-1:0]  i_tid,
    input  wire logic [ppws_pkg::STAT_W-1:0] i_status,
    input  wire logic [ppws_pkg::RTT_W-1:0]  i_rtt,
    output logic                             o_job_vld,
    output ppws_pkg::t_job                   o_job,
    input  wire logic                        i_job_pop
);

    ppws_pkg::t_job                    r_q [ppws_pkg::QDEPTH];
    logic [ppws_pkg::QPTR_W-1:0]       r_wp, n_wp;
    logic [ppws_pkg::QPTR_W-1:0]       r_rp, n_rp;
    logic [ppws_pkg::QCNT_W-1:0]       r_cnt, n_cnt;
    logic                              keep;
    logic                              enq;
    logic                              deq;

    // monitor gaps and unknown targets are taken but dropped here
    assign keep = (i_status != ppws_pkg::STATUS_GAP) &&
                  (int'(i_tid) < ppws_pkg::MAX_TARGETS);

    assign o_full    = (int'(r_cnt) == ppws_pkg::QDEPTH);
    assign enq       = i_push && !o_full && keep;
    assign o_job_vld = (r_cnt != '0);
    assign deq       = o_job_vld && i_job_pop;
    assign o_job     = r_q[r_rp];

    // pointer and count update
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (enq) begin
            n_wp = (int'(r_wp) == ppws_pkg::QDEPTH - 1) ? '0 : r_wp + 1'b1;
        end
        if (deq) begin
            n_rp = (int'(r_rp) == ppws_pkg::QDEPTH - 1) ? '0 : r_rp + 1'b1;
        end
        if (enq && !deq) n_cnt = r_cnt + 1'b1;
        else if (deq && !enq) n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_q[r_wp] <= '{tid: i_tid, status: i_status, rtt: i_rtt};
        end
    end

endmodule
`default_nettype wire

// ----- design/ppws_back.sv -----
`default_nettype none
module ppws_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [ppws_pkg::RTT_W-1:0] i_missing,
    input  wire logic                       i_job_vld,
    input  wire ppws_pkg::t_job             i_job,
    output logic                            o_job_pop,
    output logic                            o_res_vld,
    output ppws_pkg::t_res                  o_res,
    input  wire logic                       i_pop
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_UPD  = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state                             r_state, n_state;
    ppws_pkg::t_job                     r_job, n_job;
    logic [ppws_pkg::WADDR_W-1:0]       r_base, n_base;
    logic [ppws_pkg::MAX_TARGETS-1:0]   r_tvalid, n_tvalid;
    logic [ppws_pkg::TOT_W-1:0]         r_sent, n_sent;
    logic [ppws_pkg::TOT_W-1:0]         r_lost, n_lost;
    logic [ppws_pkg::FILL_W-1:0]        r_fill, n_fill;
    logic [ppws_pkg::FILL_W-1:0]        r_idx, n_idx;
    logic                               r_pend, n_pend;
    logic [ppws_pkg::FILL_W-1:0]        r_lcnt, n_lcnt;
    logic [ppws_pkg::FILL_W-1:0]        r_vcnt, n_vcnt;
    logic [ppws_pkg::RTT_W-1:0]         r_min, n_min;
    logic [ppws_pkg::RTT_W-1:0]         r_max, n_max;
    logic [ppws_pkg::SUM_W-1:0]         r_sum, n_sum;
    logic                               r_res_vld, n_res_vld;
    ppws_pkg::t_res                     r_res, n_res;

    logic [ppws_pkg::TADDR_W-1:0]       meta_raddr;
    logic [ppws_pkg::TADDR_W-1:0]       taddr;
    logic [ppws_pkg::META_W-1:0]        meta_rdata;
    ppws_pkg::t_meta                    meta_cur;
    ppws_pkg::t_meta                    meta_new;
    logic                               meta_we;
    logic [ppws_pkg::HEAD_W-1:0]        head_eff;
    logic                               win_we;
    logic [ppws_pkg::WADDR_W-1:0]       win_waddr;
    logic [ppws_pkg::WADDR_W-1:0]       win_raddr;
    logic [ppws_pkg::RTT_W-1:0]         win_rdata;
    logic                               res_load;

    assign taddr      = ppws_pkg::TADDR_W'(r_job.tid);
    assign meta_raddr = (r_state == S_IDLE) ? ppws_pkg::TADDR_W'(i_job.tid) : taddr;
    assign o_job_pop  = (r_state == S_IDLE) && i_job_vld;
    assign res_load   = (r_state == S_DONE) && (!r_res_vld || i_pop);
    assign o_res_vld  = r_res_vld;
    assign o_res      = r_res;

    // per-target entry; an entry never written since reset reads as zero
    assign meta_cur = r_tvalid[taddr] ? ppws_pkg::t_meta'(meta_rdata) : '0;

    always_comb begin
        head_eff = (int'(meta_cur.head) >= ppws_pkg::WINDOW_LEN) ? '0 : meta_cur.head;
        meta_new.sent = ppws_pkg::sat_inc(meta_cur.sent);
        meta_new.lost = (r_job.status != ppws_pkg::STATUS_OK) ?
                        ppws_pkg::sat_inc(meta_cur.lost) : meta_cur.lost;
        meta_new.head = (int'(head_eff) == ppws_pkg::WINDOW_LEN - 1) ?
                        '0 : head_eff + 1'b1;
        meta_new.fill = (int'(meta_cur.fill) < ppws_pkg::WINDOW_LEN) ?
                        meta_cur.fill + 1'b1 : meta_cur.fill;
    end

    assign meta_we   = (r_state == S_UPD);
    assign win_we    = (r_state == S_UPD);
    assign win_waddr = r_base + ppws_pkg::WADDR_W'(head_eff);
    assign win_raddr = r_base + ppws_pkg::WADDR_W'(r_idx);

    // sequencer: read entry, update, scan window, hand off result
    always_comb begin
        n_state   = r_state;
        n_job     = r_job;
        n_base    = r_base;
        n_tvalid  = r_tvalid;
        n_sent    = r_sent;
        n_lost    = r_lost;
        n_fill    = r_fill;
        n_idx     = r_idx;
        n_pend    = r_pend;
        n_lcnt    = r_lcnt;
        n_vcnt    = r_vcnt;
        n_min     = r_min;
        n_max     = r_max;
        n_sum     = r_sum;
        n_res_vld = r_res_vld;
        n_res     = r_res;

        if (r_res_vld && i_pop) n_res_vld = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_job_vld) begin
                    n_job   = i_job;
                    n_base  = ppws_pkg::WADDR_W'(ppws_pkg::WADDR_W'(i_job.tid) *
                              ppws_pkg::WADDR_W'(ppws_pkg::WINDOW_LEN));
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                n_tvalid[taddr] = 1'b1;
                n_sent  = meta_new.sent;
                n_lost  = meta_new.lost;
                n_fill  = meta_new.fill;
                n_idx   = '0;
                n_pend  = 1'b0;
                n_lcnt  = '0;
                n_vcnt  = '0;
                n_min   = '0;
                n_max   = '0;
                n_sum   = '0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                // issue next slot read
                if (r_idx != r_fill) begin
                    n_idx  = r_idx + 1'b1;
                    n_pend = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                // fold in the slot read last cycle
                if (r_pend) begin
                    if (win_rdata == i_missing) begin
                        n_lcnt = r_lcnt + 1'b1;
                    end else begin
                        if (r_vcnt == '0 || win_rdata < r_min) n_min = win_rdata;
                        if (r_vcnt == '0 || win_rdata > r_max) n_max = win_rdata;
                        n_sum  = r_sum + ppws_pkg::SUM_W'(win_rdata);
                        n_vcnt = r_vcnt + 1'b1;
                    end
                end
                if (r_idx == r_fill && !r_pend) n_state = S_DONE;
            end
            S_DONE: begin
                if (res_load) begin
                    n_res_vld = 1'b1;
                    n_res.target_id_res   = r_job.tid;
                    n_res.window_count    = ppws_pkg::sat_cnt(r_fill);
                    n_res.window_lost     = ppws_pkg::sat_cnt(r_lcnt);
                    n_res.rtt_valid_count = ppws_pkg::sat_cnt(r_vcnt);
                    n_res.rtt_min         = r_min;
                    n_res.rtt_max         = r_max;
                    n_res.rtt_sum         = ppws_pkg::sat_sum(r_sum);
                    n_res.total_sent      = r_sent;
                    n_res.total_lost      = r_lost;
                    n_res.last_status     = r_job.status;
                    n_res.last_rtt        = r_job.rtt;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_tvalid  <= '0;
            r_pend    <= 1'b0;
            r_res_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_tvalid  <= n_tvalid;
            r_pend    <= n_pend;
            r_res_vld <= n_res_vld;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_job  <= n_job;
        r_base <= n_base;
        r_sent <= n_sent;
        r_lost <= n_lost;
        r_fill <= n_fill;
        r_idx  <= n_idx;
        r_lcnt <= n_lcnt;
        r_vcnt <= n_vcnt;
        r_min  <= n_min;
        r_max  <= n_max;
        r_sum  <= n_sum;
        r_res  <= n_res;
    end

    // per-target counters, fill and head
    ppws_ram #(
        .WIDTH (ppws_pkg::META_W),
        .DEPTH (ppws_pkg::MAX_TARGETS)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (taddr),
        .i_wdata (ppws_pkg::META_W'(meta_new)),
        .i_raddr (meta_raddr),
        .o_rdata (meta_rdata)
    );

    // RTT windows, one row of slots per target
    ppws_ram #(
        .WIDTH (ppws_pkg::RTT_W),
        .DEPTH (ppws_pkg::MAX_TARGETS * ppws_pkg::WINDOW_LEN)
    ) u_win_ram (
        .i_clk   (i_clk),
        .i_we    (win_we),
        .i_waddr (win_waddr),
        .i_wdata (r_job.rtt),
        .i_raddr (win_raddr),
        .o_rdata (win_rdata)
    );

endmodule
`default_nettype wire

// ----- design/per_target_probe_window_stats.sv -----
// Flow: an item with a result passes entry read, update, a scan of the F filled window slots
//   (F = window fill after the update, up to 10), then hand-off once the result slot is free.
// The back end takes one item at a time and finishes it before the next, set by the window scan
//   through the single read port of the window RAM; a 2-item queue takes items meanwhile.
// Reset: synchronous, active low; clears all per-target counters and window fills at once via
//   per-target valid bits, and sets the missing code to 0xFFFF. No clearing pass.
`default_nettype none
module per_target_probe_window_stats (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           push,
    output logic                                full,
    input  wire logic [ppws_pkg::TID_W-1:0]     i_target_id,
    input  wire logic [ppws_pkg::STAT_W-1:0]    i_status,
    input  wire logic [ppws_pkg::RTT_W-1:0]     i_rtt_tenths,
    output logic                                empty,
    input  wire logic                           pop,
    output logic [ppws_pkg::TID_W-1:0]          o_target_id_res,
    output logic [ppws_pkg::CNT_W-1:0]          o_window_count,
    output logic [ppws_pkg::CNT_W-1:0]          o_window_lost,
    output logic [ppws_pkg::CNT_W-1:0]          o_rtt_valid_count,
    output logic [ppws_pkg::RTT_W-1:0]          o_rtt_min,
    output logic [ppws_pkg::RTT_W-1:0]          o_rtt_max,
    output logic [ppws_pkg::SUM_OUT_W-1:0]      o_rtt_sum,
    output logic [ppws_pkg::TOT_W-1:0]          o_total_sent,
    output logic [ppws_pkg::TOT_W-1:0]          o_total_lost,
    output logic [ppws_pkg::STAT_W-1:0]         o_last_status,
    output logic [ppws_pkg::RTT_W-1:0]          o_last_rtt,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [ppws_pkg::RTT_W-1:0]     i_cfg_data
);

    logic [ppws_pkg::RTT_W-1:0] r_missing;
    logic                       job_vld;
    ppws_pkg::t_job             job;
    logic                       job_pop;
    logic                       res_vld;
    ppws_pkg::t_res             res;

    // missing-code register, always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_missing <= ppws_pkg::MISSING_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_missing <= i_cfg_data;
        end
    end

    ppws_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .o_full    (full),
        .i_tid     (i_target_id),
        .i_status  (i_status),
        .i_rtt     (i_rtt_tenths),
        .o_job_vld (job_vld),
        .o_job     (job),
        .i_job_pop (job_pop)
    );

    ppws_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_missing (r_missing),
        .i_job_vld (job_vld),
        .i_job     (job),
        .o_job_pop (job_pop),
        .o_res_vld (res_vld),
        .o_res     (res),
        .i_pop     (pop)
    );

    // result ports
    assign empty             = !res_vld;
    assign o_target_id_res   = res.target_id_res;
    assign o_window_count    = res.window_count;
    assign o_window_lost     = res.window_lost;
    assign o_rtt_valid_count = res.rtt_valid_count;
    assign o_rtt_min         = res.rtt_min;
    assign o_rtt_max         = res.rtt_max;
    assign o_rtt_sum         = res.rtt_sum;
    assign o_total_sent      = res.total_sent;
    assign o_total_lost      = res.total_lost;
    assign o_last_status     = res.last_status;
    assign o_last_rtt        = res.last_rtt;

endmodule
`default_nettype wire

// ----- design/ppws_checker.sv -----
`default_nettype none
module ppws_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           full,
    input wire logic                           empty,
    input wire logic                           pop,
    input wire logic [ppws_pkg::TID_W-1:0]     o_target_id_res,
    input wire logic [ppws_pkg::CNT_W-1:0]     o_window_count,
    input wire logic [ppws_pkg::CNT_W-1:0]     o_window_lost,
    input wire logic [ppws_pkg::CNT_W-1:0]     o_rtt_valid_count,
    input wire logic [ppws_pkg::RTT_W-1:0]     o_rtt_min,
    input wire logic [ppws_pkg::RTT_W-1:0]     o_rtt_max,
    input wire logic [ppws_pkg::SUM_OUT_W-1:0] o_rtt_sum,
    input wire logic [ppws_pkg::TOT_W-1:0]     o_total_sent,
    input wire logic [ppws_pkg::TOT_W-1:0]     o_total_lost
);

    // after reset nothing is pending on either side
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    // a waiting result holds until taken
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_target_id_res) && $stable(o_total_sent)
                           && $stable(o_rtt_sum))
        else $error("result changed while waiting");

    // window split into lost and valid entries, never empty
    a_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (5'(o_window_lost) + 5'(o_rtt_valid_count) == 5'(o_window_count))
                   && (o_window_count != '0))
        else $error("window counts inconsistent");

    // no valid RTT means zero statistics
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && (o_rtt_valid_count == '0) |->
            (o_rtt_min == '0) && (o_rtt_max == '0) && (o_rtt_sum == '0))
        else $error("statistics nonzero with no valid RTT");

    // ordered extremes, a nonzero sent count and a lost count that never exceeds the sent count
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_rtt_min <= o_rtt_max) && (o_total_lost <= o_total_sent)
                   && (o_total_sent != '0))
        else $error("result ordering broken");

endmodule

bind per_target_probe_window_stats ppws_checker u_ppws_checker (.*);
`default_nettype wire
